// ===== design/bcf_pkg.sv =====
// shared types and constants for the bezier curve flattener
`default_nettype none
package bcf_pkg;

   localparam int COORD_W           = 16;
   localparam int TOL_W             = 16;
   localparam int DEFAULT_MAX_DEPTH = 6;
   localparam int COORD_FRAC_BITS   = 4;
   localparam int QUEUE_DEPTH       = 2;

   localparam logic [TOL_W-1:0] TOL_RESET = 16'd64;

   // floor((n + 1) / 3) via bias and reciprocal multiply
   localparam int              THIRD_W     = 20;
   localparam logic [19:0]     THIRD_BIAS  = 20'd196609;
   localparam logic [19:0]     THIRD_RECIP = 20'd699051;
   localparam int              THIRD_SHIFT = 21;

   // flatness compare alignment
   localparam int CMP_W   = 72;
   localparam int CMP_SHL = (2 * COORD_FRAC_BITS >= 8) ? 0 : 8 - 2 * COORD_FRAC_BITS;
   localparam int CMP_SHR = (2 * COORD_FRAC_BITS >= 8) ? 2 * COORD_FRAC_BITS - 8 : 0;

   typedef logic signed [COORD_W-1:0] bcf_coord_type;

   typedef struct packed {
      logic          kind;
      bcf_coord_type start_x;
      bcf_coord_type start_y;
      bcf_coord_type ctrl1_x;
      bcf_coord_type ctrl1_y;
      bcf_coord_type ctrl2_x;
      bcf_coord_type ctrl2_y;
      bcf_coord_type end_x;
      bcf_coord_type end_y;
   } bcf_req_type;

   typedef struct packed {
      bcf_coord_type point_x;
      bcf_coord_type point_y;
      logic          is_last;
   } bcf_rsp_type;

   // control polygon on the input grid, index 0 start to 3 end
   typedef struct packed {
      logic [3:0][COORD_W-1:0] px;
      logic [3:0][COORD_W-1:0] py;
   } bcf_curve_type;

endpackage
`default_nettype wire

// ===== design/bezier_curve_flattener.sv =====
// top level: cubic and quadratic bezier flattener by adaptive halving
// the first point follows a flatness test of the first piece; a quadratic first passes the
//   front end's four raise steps, and each split on the way down adds a further test
// pieces at the depth cap are emitted without a test; while the engine works through a curve,
//   the front end accepts and queues the next one until the queue is full
// reset: synchronous, clears the state machines, queue and stack, tolerance to 64
`default_nettype none
module bezier_curve_flattener
   import bcf_pkg::*;
#(
   parameter int MAX_DEPTH = DEFAULT_MAX_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire bcf_req_type       req_data,
   output logic                   rsp_valid,
   output bcf_rsp_type            rsp_data,
   input  wire logic              csr_we,
   input  wire logic [TOL_W-1:0]  csr_wdata
);

   logic [TOL_W-1:0] tolerance_ff;
   logic             push, full, pop, empty;
   bcf_curve_type    push_data, pop_data;

   always_ff @(posedge clock) begin
      if (reset)       tolerance_ff <= TOL_RESET;
      else if (csr_we) tolerance_ff <= csr_wdata;
   end

   bcf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .push      (push),
      .push_data (push_data),
      .full      (full)
   );

   bcf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   bcf_back #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .tolerance (tolerance_ff),
      .empty     (empty),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ===== design/bcf_front.sv =====
// front end: accepts curves and raises quadratics to cubics
`default_nettype none
module bcf_front
   import bcf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire bcf_req_type   req_data,
   output logic               push,
   output bcf_curve_type      push_data,
   input  wire logic          full
);

   typedef enum logic [2:0] {
      F_IDLE  = 3'b001,
      F_RAISE = 3'b010,
      F_PUSH  = 3'b100
   } front_state_type;

   front_state_type      state_ff, state_in;
   logic [1:0]           step_ff;
   bcf_curve_type        curve_ff;
   logic [COORD_W-1:0]   ctrl_x_ff, ctrl_y_ff;

   logic                 accept;
   logic [COORD_W-1:0]   base;
   logic [COORD_W-1:0]   ctl;
   logic signed [17:0]   num;
   logic [THIRD_W-1:0]   biased;
   logic [2*THIRD_W-1:0] prod;
   logic [COORD_W-1:0]   third_q;

   assign busy      = (state_ff != F_IDLE);
   assign accept    = start && !busy;
   assign push      = (state_ff == F_PUSH) && !full;
   assign push_data = curve_ff;

   always_comb begin
      case (step_ff)
         2'd0:    begin base = curve_ff.px[0]; ctl = ctrl_x_ff; end
         2'd1:    begin base = curve_ff.py[0]; ctl = ctrl_y_ff; end
         2'd2:    begin base = curve_ff.px[3]; ctl = ctrl_x_ff; end
         default: begin base = curve_ff.py[3]; ctl = ctrl_y_ff; end
      endcase
      num     = 18'($signed(base)) + (18'($signed(ctl)) <<< 1);
      biased  = THIRD_W'(num) + THIRD_BIAS;
      prod    = biased * THIRD_RECIP;
      // the grid offset only touches bits above the result
      third_q = prod[THIRD_SHIFT +: COORD_W];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE:  if (accept) state_in = req_data.kind ? F_RAISE : F_PUSH;
         F_RAISE: if (step_ff == 2'd3) state_in = F_PUSH;
         F_PUSH:  if (!full) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         step_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         if (state_ff == F_RAISE) step_ff <= step_ff + 2'd1;
         else                     step_ff <= 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         curve_ff.px <= {req_data.end_x, req_data.ctrl2_x, req_data.ctrl1_x, req_data.start_x};
         curve_ff.py <= {req_data.end_y, req_data.ctrl2_y, req_data.ctrl1_y, req_data.start_y};
         ctrl_x_ff   <= req_data.ctrl1_x;
         ctrl_y_ff   <= req_data.ctrl1_y;
      end else if (state_ff == F_RAISE) begin
         case (step_ff)
            2'd0:    curve_ff.px[1] <= third_q;
            2'd1:    curve_ff.py[1] <= third_q;
            2'd2:    curve_ff.px[2] <= third_q;
            default: curve_ff.py[2] <= third_q;
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== design/bcf_queue.sv =====
// short curve queue between front end and subdivision engine
`default_nettype none
module bcf_queue
   import bcf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire bcf_curve_type push_data,
   output logic               full,
   input  wire logic          pop,
   output bcf_curve_type      pop_data,
   output logic               empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   bcf_curve_type     mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule
`default_nettype wire

// ===== design/bcf_back.sv =====
// subdivision engine: flatness test, de casteljau split and point output
`default_nettype none
module bcf_back
   import bcf_pkg::*;
#(
   parameter int MAX_DEPTH = DEFAULT_MAX_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [TOL_W-1:0]  tolerance,
   input  wire logic              empty,
   input  wire bcf_curve_type     pop_data,
   output logic                   pop,
   output logic                   rsp_valid,
   output bcf_rsp_type            rsp_data
);

   localparam int EXT     = 3 * MAX_DEPTH;
   localparam int CW      = COORD_W + EXT;
   localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
   localparam int SP_W    = DEPTH_W;
   localparam int IDX_W   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int DW      = COORD_W + 1;

   typedef enum logic [7:0] {
      B_IDLE   = 8'b00000001,
      B_DIFF   = 8'b00000010,
      B_MUL    = 8'b00000100,
      B_SUM    = 8'b00001000,
      B_SQ     = 8'b00010000,
      B_DECIDE = 8'b00100000,
      B_SPLIT  = 8'b01000000,
      B_EMIT   = 8'b10000000
   } back_state_type;

   typedef struct packed {
      logic [DEPTH_W-1:0]  depth;
      logic [3:0][CW-1:0]  px;
      logic [3:0][CW-1:0]  py;
   } piece_type;

   function automatic logic [CW-1:0] half_sum(logic [CW-1:0] a, logic [CW-1:0] b);
      logic signed [CW:0] s;
      s = (CW+1)'($signed(a)) + (CW+1)'($signed(b));
      return s[CW:1];
   endfunction

   // [3:0] low half, [7:4] high half
   function automatic logic [7:0][CW-1:0] split_axis(logic [3:0][CW-1:0] c);
      logic [CW-1:0] ab, bc, cd, abc, bcd, mid;
      ab  = half_sum(c[0], c[1]);
      bc  = half_sum(c[1], c[2]);
      cd  = half_sum(c[2], c[3]);
      abc = half_sum(ab, bc);
      bcd = half_sum(bc, cd);
      mid = half_sum(abc, bcd);
      return {c[3], cd, bcd, mid, mid, abc, ab, c[0]};
   endfunction

   function automatic logic signed [DW-1:0] grid(logic [CW-1:0] v);
      return DW'($signed(v[EXT +: COORD_W]));
   endfunction

   back_state_type         state_ff, state_in;
   piece_type              piece_ff;
   piece_type              stack_ff [MAX_DEPTH];
   logic [SP_W-1:0]        sp_ff;
   logic [SP_W-1:0]        sp_dec;

   logic signed [DW-1:0]   cx_ff, cy_ff, ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [2*DW-1:0] p1_ff, p2_ff, p3_ff, p4_ff, p5_ff, p6_ff;
   logic signed [2*DW:0]   d1, d2;
   logic [2*DW:0]          mag1, mag2;
   logic [2*DW+1:0]        err;
   logic                   err_big_ff;
   logic [31:0]            err_ff;
   logic [2*DW-1:0]        chord2_ff;
   logic [63:0]            sq_ff;
   logic [TOL_W+2*DW-1:0]  rhs_ff;
   logic                   flat;
   logic                   at_cap;
   logic [7:0][CW-1:0]     sx, sy;

   logic                   rsp_valid_ff;
   bcf_rsp_type            rsp_data_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pop       = (state_ff == B_IDLE) && !empty;
   assign sp_dec    = sp_ff - SP_W'(1);
   assign at_cap    = (piece_ff.depth == DEPTH_W'(MAX_DEPTH));
   assign sx        = split_axis(piece_ff.px);
   assign sy        = split_axis(piece_ff.py);

   always_comb begin
      d1   = (2*DW+1)'(p1_ff) - (2*DW+1)'(p2_ff);
      d2   = (2*DW+1)'(p3_ff) - (2*DW+1)'(p4_ff);
      mag1 = d1[2*DW] ? (2*DW+1)'(-d1) : (2*DW+1)'(d1);
      mag2 = d2[2*DW] ? (2*DW+1)'(-d2) : (2*DW+1)'(d2);
      err  = (2*DW+2)'(mag1) + (2*DW+2)'(mag2);
      flat = !err_big_ff && ((CMP_W'(sq_ff) << CMP_SHL) < (CMP_W'(rhs_ff) << CMP_SHR));
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE:   if (!empty) state_in = B_DIFF;
         B_DIFF:   state_in = at_cap ? B_EMIT : B_MUL;
         B_MUL:    state_in = B_SUM;
         B_SUM:    state_in = B_SQ;
         B_SQ:     state_in = B_DECIDE;
         B_DECIDE: state_in = flat ? B_EMIT : B_SPLIT;
         B_SPLIT:  state_in = B_DIFF;
         B_EMIT:   state_in = (sp_ff == '0) ? B_IDLE : B_DIFF;
         default:  state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == B_EMIT);
         if (state_ff == B_SPLIT)                     sp_ff <= sp_ff + SP_W'(1);
         else if (state_ff == B_EMIT && sp_ff != '0)  sp_ff <= sp_dec;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         B_IDLE: begin
            for (int i = 0; i < 4; i++) begin
               piece_ff.px[i] <= {pop_data.px[i], EXT'(0)};
               piece_ff.py[i] <= {pop_data.py[i], EXT'(0)};
            end
            piece_ff.depth <= '0;
         end
         B_DIFF: begin
            cx_ff <= grid(piece_ff.px[3]) - grid(piece_ff.px[0]);
            cy_ff <= grid(piece_ff.py[3]) - grid(piece_ff.py[0]);
            ax_ff <= grid(piece_ff.px[1]) - grid(piece_ff.px[3]);
            ay_ff <= grid(piece_ff.py[1]) - grid(piece_ff.py[3]);
            bx_ff <= grid(piece_ff.px[2]) - grid(piece_ff.px[3]);
            by_ff <= grid(piece_ff.py[2]) - grid(piece_ff.py[3]);
         end
         B_MUL: begin
            p1_ff <= ax_ff * cy_ff;
            p2_ff <= ay_ff * cx_ff;
            p3_ff <= bx_ff * cy_ff;
            p4_ff <= by_ff * cx_ff;
            p5_ff <= cx_ff * cx_ff;
            p6_ff <= cy_ff * cy_ff;
         end
         B_SUM: begin
            err_big_ff <= |err[2*DW+1:32];
            err_ff     <= err[31:0];
            // squares are never negative
            chord2_ff  <= (2*DW)'(p5_ff[2*DW-2:0]) + (2*DW)'(p6_ff[2*DW-2:0]);
         end
         B_SQ: begin
            sq_ff  <= err_ff * err_ff;
            rhs_ff <= (TOL_W+2*DW)'(tolerance) * (TOL_W+2*DW)'(chord2_ff);
         end
         B_DECIDE: begin
         end
         B_SPLIT: begin
            // walk the low half now, park the high half
            piece_ff.px    <= sx[3:0];
            piece_ff.py    <= sy[3:0];
            piece_ff.depth <= piece_ff.depth + DEPTH_W'(1);
            stack_ff[sp_ff[IDX_W-1:0]].px    <= sx[7:4];
            stack_ff[sp_ff[IDX_W-1:0]].py    <= sy[7:4];
            stack_ff[sp_ff[IDX_W-1:0]].depth <= piece_ff.depth + DEPTH_W'(1);
         end
         B_EMIT: begin
            rsp_data_ff.point_x <= piece_ff.px[3][EXT +: COORD_W];
            rsp_data_ff.point_y <= piece_ff.py[3][EXT +: COORD_W];
            rsp_data_ff.is_last <= (sp_ff == '0);
            if (sp_ff != '0) piece_ff <= stack_ff[sp_dec[IDX_W-1:0]];
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire
